@@ hdl/tsae_pkg.sv @@
// Package for the TDM slot activity energy block: slot state type, sizes,
// register indexes and limits. No dependencies.
package tsae_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int ADDR_W = 4;

	localparam logic [12:0] FRAME_MAX = 13'd4096;
	localparam logic [4:0]  SEG_MAX   = 5'd16;

	localparam logic [12:0] FPS_RESET   = 13'd256;
	localparam logic [4:0]  SPW_RESET   = 5'd2;
	localparam logic [4:0]  SHIFT_RESET = 5'd9;
	localparam logic [15:0] THR_RESET   = 16'd10;

	// register indexes (word address)
	localparam logic [1:0] REG_FPS   = 2'd0;
	localparam logic [1:0] REG_SPW   = 2'd1;
	localparam logic [1:0] REG_SHIFT = 2'd2;
	localparam logic [1:0] REG_THR   = 2'd3;

	typedef struct packed {
		logic [15:0] prev;
		logic [31:0] acc;
	} cell_t;

endpackage

@@ hdl/tsae_cell.sv @@
// One slot cell of the state ring: previous sample and energy sum.
// Depends on tsae_pkg.
module tsae_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tsae_pkg::cell_t d,
	output tsae_pkg::cell_t q
);

	logic [15:0] prev_q;
	logic [31:0] acc_q;

	// sum clears at reset, previous sample is written before it is ever used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= d.acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prev_q <= d.prev;
		end
	end

	assign q.prev = prev_q;
	assign q.acc  = acc_q;

endmodule

@@ hdl/tsae_head.sv @@
// Update logic at the head of the ring: absolute frame difference and
// accumulate, or clear the sum on a report pass. Depends on tsae_pkg.
module tsae_head (
	input  tsae_pkg::cell_t cur,
	input  logic [15:0]     sample,
	input  logic            compare,
	input  logic            report,
	output tsae_pkg::cell_t nxt
);

	logic [15:0] diff;
	logic [16:0] mag;

	always_comb begin
		diff = sample - cur.prev;
		// wrapped difference read as two's complement, then made absolute
		mag  = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
		if (report) begin
			nxt.prev = cur.prev;
			nxt.acc  = '0;
		end else begin
			nxt.prev = sample;
			nxt.acc  = compare ? (cur.acc + {15'd0, mag}) : cur.acc;
		end
	end

endmodule

@@ hdl/tdm_slot_activity_energy.sv @@
// TDM slot activity energy: samples arrive one per transfer with the slots in
// fixed rotation, slot 0 first. Each slot keeps its previous sample and a 32-bit
// sum of absolute frame-to-frame differences (difference wrapped to 16 bits);
// the first frame of every segment is stored only. Slot state lives in a ring
// of SLOTS cells that rotates by one cell per accepted sample, so the slot being
// served always sits in the head cell. A sample can be taken every cycle outside
// a report run. On the sample that closes the last frame of a window the block
// stops taking samples and rotates the ring once more, one cell per result
// transfer, reporting each slot (sum, sum shifted right by mean_shift, active
// flag, last on the final slot) and clearing its sum; the report run pauses
// while result_stall is held. Registers, word addressed over the APB port:
// 0 frames_per_segment, 1 segments_per_window, 2 mean_shift, 3 activity_threshold.
// Depends on tsae_pkg, tsae_cell, tsae_head.
module tdm_slot_activity_energy (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsae_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// sample channel
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [15:0]            sample,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [3:0]                    slot_index,
	output logic [31:0]                   energy_sum,
	output logic [31:0]                   mean_energy,
	output logic                          active,
	output logic                          last
);

	typedef enum logic {
		ST_RUN,
		ST_REPORT
	} state_t;

	state_t state_q;

	logic [12:0] fps_q;
	logic [4:0]  spw_q;
	logic [4:0]  shift_q;
	logic [15:0] thr_q;

	logic [tsae_pkg::SLOT_W-1:0] slot_q;
	logic [tsae_pkg::SLOT_W-1:0] rpt_cnt_q;
	logic [11:0]                 frame_cnt_q;
	logic [3:0]                  seg_cnt_q;

	tsae_pkg::cell_t cell_q [tsae_pkg::SLOTS];
	tsae_pkg::cell_t tail;

	logic        smp_xfer;
	logic        load_out;
	logic        shift_en;
	logic        slot_end;
	logic        frame_end;
	logic        seg_end;
	logic [12:0] flim;
	logic [4:0]  slim;
	logic [12:0] frame_nxt;
	logic [4:0]  seg_nxt;
	logic [31:0] mean;
	logic [1:0]  reg_idx;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q   <= tsae_pkg::FPS_RESET;
			spw_q   <= tsae_pkg::SPW_RESET;
			shift_q <= tsae_pkg::SHIFT_RESET;
			thr_q   <= tsae_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				tsae_pkg::REG_FPS:   fps_q   <= pwdata[12:0];
				tsae_pkg::REG_SPW:   spw_q   <= pwdata[4:0];
				tsae_pkg::REG_SHIFT: shift_q <= pwdata[4:0];
				tsae_pkg::REG_THR:   thr_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tsae_pkg::REG_FPS:   prdata = {19'd0, fps_q};
			tsae_pkg::REG_SPW:   prdata = {27'd0, spw_q};
			tsae_pkg::REG_SHIFT: prdata = {27'd0, shift_q};
			tsae_pkg::REG_THR:   prdata = {16'd0, thr_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Frame and segment limits: zero acts as one, clamp at the maxima
	// ---------------------------------------------------------------------
	always_comb begin
		if (fps_q == 13'd0) begin
			flim = 13'd1;
		end else if (fps_q > tsae_pkg::FRAME_MAX) begin
			flim = tsae_pkg::FRAME_MAX;
		end else begin
			flim = fps_q;
		end
		if (spw_q == 5'd0) begin
			slim = 5'd1;
		end else if (spw_q > tsae_pkg::SEG_MAX) begin
			slim = tsae_pkg::SEG_MAX;
		end else begin
			slim = spw_q;
		end
	end

	assign frame_nxt = {1'b0, frame_cnt_q} + 13'd1;
	assign seg_nxt   = {1'b0, seg_cnt_q} + 5'd1;
	assign slot_end  = (slot_q == tsae_pkg::SLOT_W'(tsae_pkg::SLOTS - 1));
	assign frame_end = (frame_nxt >= flim);
	assign seg_end   = (seg_nxt >= slim);

	// ---------------------------------------------------------------------
	// Handshakes: hold off samples for the whole report run
	// ---------------------------------------------------------------------
	assign sample_stall = (state_q == ST_REPORT);
	assign smp_xfer     = sample_valid && !sample_stall;
	assign load_out     = (state_q == ST_REPORT) && (!result_valid || !result_stall);
	assign shift_en     = smp_xfer || load_out;

	// ---------------------------------------------------------------------
	// Slot ring: head cell is the slot being served, its update enters at the tail
	// ---------------------------------------------------------------------
	tsae_head u_head (
		.cur     (cell_q[0]),
		.sample  (sample),
		.compare (frame_cnt_q != 12'd0),
		.report  (state_q == ST_REPORT),
		.nxt     (tail)
	);

	for (genvar i = 0; i < tsae_pkg::SLOTS; i++) begin : g_ring
		if (i == tsae_pkg::SLOTS - 1) begin : g_tail
			tsae_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (shift_en),
				.d      (tail),
				.q      (cell_q[i])
			);
		end else begin : g_body
			tsae_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (shift_en),
				.d      (cell_q[i+1]),
				.q      (cell_q[i])
			);
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer: slot, frame and segment counts; report run
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			slot_q      <= '0;
			rpt_cnt_q   <= '0;
			frame_cnt_q <= '0;
			seg_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (smp_xfer) begin
						if (!slot_end) begin
							slot_q <= slot_q + 1'b1;
						end else begin
							slot_q <= '0;
							if (!frame_end) begin
								frame_cnt_q <= frame_nxt[11:0];
							end else begin
								frame_cnt_q <= '0;
								if (!seg_end) begin
									seg_cnt_q <= seg_nxt[3:0];
								end else begin
									seg_cnt_q <= '0;
									rpt_cnt_q <= '0;
									state_q   <= ST_REPORT;
								end
							end
						end
					end
				end
				ST_REPORT: begin
					if (load_out) begin
						if (rpt_cnt_q == tsae_pkg::SLOT_W'(tsae_pkg::SLOTS - 1)) begin
							rpt_cnt_q <= '0;
							state_q   <= ST_RUN;
						end else begin
							rpt_cnt_q <= rpt_cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Result register: parts the ring from the result channel
	// ---------------------------------------------------------------------
	assign mean = cell_q[0].acc >> shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_out) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			slot_index  <= 4'(rpt_cnt_q);
			energy_sum  <= cell_q[0].acc;
			mean_energy <= mean;
			active      <= (mean >= {16'd0, thr_q});
			last        <= (rpt_cnt_q == tsae_pkg::SLOT_W'(tsae_pkg::SLOTS - 1));
		end
	end

`ifndef SYNTHESIS
	// a report run starts with every count back at its origin
	a_report_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_REPORT) |->
			(slot_q == '0) && (frame_cnt_q == '0) && (seg_cnt_q == '0))
		else $error("report run started with counts not at origin");

	// loading the final slot of a run ends the run and presents that slot as last
	a_last_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (rpt_cnt_q == tsae_pkg::SLOT_W'(tsae_pkg::SLOTS - 1))) |=>
			(state_q == ST_RUN) && result_valid && last)
		else $error("last result loaded without ending the report run");

	// leaving the report run always leaves the last result pending
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == ST_REPORT) |-> (result_valid && last))
		else $error("report run ended without last result");
`endif

endmodule

@@ test/tsae_energy_checker.sv @@
// Checker for the TDM slot activity energy block: watches the register port and
// both transfer channels, predicts every slot report and compares it field by field.
// Depends on tsae_pkg for sizes, register indexes and reset values.
module tsae_energy_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsae_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  logic signed [15:0]            sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [3:0]                    slot_index,
	input  logic [31:0]                   energy_sum,
	input  logic [31:0]                   mean_energy,
	input  logic                          active,
	input  logic                          last,
	output int                            fault_count,
	output int                            reports_due,
	output int                            reports_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  slot;
		logic [31:0] sum;
		logic [31:0] mean;
		logic        act;
		logic        fin;
	} slot_report_t;

	// register copies
	logic [12:0] fps_q;
	logic [4:0]  spw_q;
	logic [4:0]  shift_q;
	logic [15:0] thr_q;

	// slot state
	logic [15:0] prev_smp [tsae_pkg::SLOTS];
	logic [31:0] energy [tsae_pkg::SLOTS];
	int          slot_ptr;
	int          frame_cnt;
	int          seg_cnt;

	slot_report_t report_queue [$];
	slot_report_t want;
	logic [31:0]  reg_now;

	wire [1:0] reg_idx = paddr[tsae_pkg::ADDR_W-1:2];

	initial fault_count = 0;

	function automatic void check_field(string name, logic [31:0] expected_val,
			logic [31:0] actual_val);
		if (actual_val !== expected_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, expected_val, actual_val);
			fault_count++;
		end
	endfunction

	// Fold one sample into its slot; on the close of a window queue one report per slot.
	function automatic void accumulate_sample(logic [15:0] s);
		logic [15:0]  diff;
		int           frame_lim;
		int           seg_lim;
		slot_report_t r;
		diff = s - prev_smp[slot_ptr];
		if (frame_cnt != 0)
			energy[slot_ptr] += diff[15] ? 32'h10000 - {16'd0, diff} : {16'd0, diff};
		prev_smp[slot_ptr] = s;
		slot_ptr++;
		if (slot_ptr < tsae_pkg::SLOTS) return;
		slot_ptr = 0;

		frame_lim = (fps_q < 13'd1) ? 1 :
			(fps_q > tsae_pkg::FRAME_MAX) ? int'(tsae_pkg::FRAME_MAX) : int'(fps_q);
		frame_cnt++;
		if (frame_cnt < frame_lim) return;
		frame_cnt = 0;

		seg_lim = (spw_q < 5'd1) ? 1 :
			(spw_q > tsae_pkg::SEG_MAX) ? int'(tsae_pkg::SEG_MAX) : int'(spw_q);
		seg_cnt++;
		if (seg_cnt < seg_lim) return;
		seg_cnt = 0;

		for (int k = 0; k < tsae_pkg::SLOTS; k++) begin
			r.slot = 4'(k);
			r.sum  = energy[k];
			r.mean = energy[k] >> shift_q;
			r.act  = (r.mean >= {16'd0, thr_q});
			r.fin  = (k == tsae_pkg::SLOTS - 1);
			report_queue.push_back(r);
			energy[k] = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q     = tsae_pkg::FPS_RESET;
			spw_q     = tsae_pkg::SPW_RESET;
			shift_q   = tsae_pkg::SHIFT_RESET;
			thr_q     = tsae_pkg::THR_RESET;
			slot_ptr  = 0;
			frame_cnt = 0;
			seg_cnt   = 0;
			for (int k = 0; k < tsae_pkg::SLOTS; k++) begin
				prev_smp[k] = '0;
				energy[k]   = '0;
			end
			report_queue.delete();
			reports_due     = 0;
			reports_checked = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx)
						tsae_pkg::REG_FPS:   fps_q   = pwdata[12:0];
						tsae_pkg::REG_SPW:   spw_q   = pwdata[4:0];
						tsae_pkg::REG_SHIFT: shift_q = pwdata[4:0];
						tsae_pkg::REG_THR:   thr_q   = pwdata[15:0];
					endcase
				end else begin
					case (reg_idx)
						tsae_pkg::REG_FPS:   reg_now = {19'd0, fps_q};
						tsae_pkg::REG_SPW:   reg_now = {27'd0, spw_q};
						tsae_pkg::REG_SHIFT: reg_now = {27'd0, shift_q};
						default:             reg_now = {16'd0, thr_q};
					endcase
					check_field("prdata", reg_now, prdata);
				end
			end

			if (sample_valid && !sample_stall)
				accumulate_sample(sample);

			if (result_valid && !result_stall) begin
				if (report_queue.size() == 0) begin
					$error("unexpected report for slot_index %0d, nothing outstanding",
						slot_index);
					fault_count++;
				end else begin
					want = report_queue.pop_front();
					check_field("slot_index", 32'(want.slot), 32'(slot_index));
					check_field("energy_sum", want.sum, energy_sum);
					check_field("mean_energy", want.mean, mean_energy);
					check_field("active", 32'(want.act), 32'(active));
					check_field("last", 32'(want.fin), 32'(last));
				end
				reports_checked++;
			end
			reports_due = report_queue.size();
		end
	end

endmodule

@@ test/tdm_slot_activity_energy_tb.sv @@
// Top of the TDM slot activity energy testbench: clock, reset, register set-up,
// sample stimulus and random stalls; the verdict comes from tsae_energy_checker.
// Depends on tsae_pkg, tdm_slot_activity_energy and tsae_energy_checker.
module tdm_slot_activity_energy_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES   = 300;	// long receiver hold-off
	localparam int SETTLE_CYCLES = 40;	// quiet cycles after the last report

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [tsae_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	logic signed [15:0]          sample = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic [3:0]                  slot_index;
	logic [31:0]                 energy_sum;
	logic [31:0]                 mean_energy;
	logic                        active;
	logic                        last;

	int fault_count;
	int reports_due;
	int reports_checked;

	// stimulus bookkeeping
	int          send_pct = 0;
	int          stall_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_left = 0;
	logic [15:0] last_tx [tsae_pkg::SLOTS];
	int          tx_slot = 0;
	int          samples_sent = 0;
	int          settings_used = 0;

	tdm_slot_activity_energy dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.slot_index   (slot_index),
		.energy_sum   (energy_sum),
		.mean_energy  (mean_energy),
		.active       (active),
		.last         (last)
	);

	tsae_energy_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.slot_index      (slot_index),
		.energy_sum      (energy_sum),
		.mean_energy     (mean_energy),
		.active          (active),
		.last            (last),
		.fault_count     (fault_count),
		.reports_due     (reports_due),
		.reports_checked (reports_checked)
	);

	always #2 clk = ~clk;

	// Receiver side. A pulse on hold_go starts a long hold-off, counted down here;
	// otherwise stall at random with the current percentage. One assignment per edge.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left > 1) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			hold_left    <= 0;
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#400_000;
		$display("Test completed with failures");
		$finish;
	end

	// Register write: setup cycle, then access cycle until pready; one idle cycle after,
	// so that back-to-back accesses never assign psel twice in one step.
	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Register read; the checker compares prdata on the access edge.
	task automatic apb_read(logic [1:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all four registers, then read each back. Only called with the block idle.
	task automatic configure(logic [31:0] fps, logic [31:0] spw, logic [31:0] shift,
			logic [31:0] thr);
		apb_write(tsae_pkg::REG_FPS, fps);
		apb_write(tsae_pkg::REG_SPW, spw);
		apb_write(tsae_pkg::REG_SHIFT, shift);
		apb_write(tsae_pkg::REG_THR, thr);
		apb_read(tsae_pkg::REG_FPS);
		apb_read(tsae_pkg::REG_SPW);
		apb_read(tsae_pkg::REG_SHIFT);
		apb_read(tsae_pkg::REG_THR);
		settings_used++;
	endtask

	// Offer one sample after a random gap and hold it until the transfer happens.
	// sample_stall is read just after the edge, so it is the value the edge saw.
	task automatic send_sample(logic [15:0] value);
		while ($urandom_range(0, 99) < send_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= value;
		do @(posedge clk); while (sample_stall);
		last_tx[tx_slot] = value;
		tx_slot = (tx_slot + 1) % tsae_pkg::SLOTS;
		samples_sent++;
	endtask

	// Wait until every predicted report has come, then a quiet stretch so that the
	// block has finished any sample still in hand before the next register write.
	task automatic settle();
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Directed samples: first frame in 0..15, second frame in 16..31. The pairs hit
	// the wrap of the 16-bit difference from both sides, the largest step of 32768,
	// no change at all, and a few ordinary steps.
	function automatic logic [15:0] directed_sample(int i);
		case (i)
			0, 3, 9, 17, 18, 25:  return 16'h8000;
			1, 5, 15, 16, 20, 31: return 16'h7FFF;
			6, 23:                return 16'hFFFF;
			8, 24:                return 16'h04D2;
			10:                   return 16'h4000;
			11, 26:               return 16'hC000;
			12:                   return 16'h0064;
			13:                   return 16'h5555;
			14:                   return 16'hFFFE;
			27:                   return 16'h4001;
			28:                   return 16'h0190;
			29:                   return 16'hAAAA;
			30:                   return 16'h7FFE;
			default:              return 16'h0000;
		endcase
	endfunction

	// Random samples with the given idling. Most are small steps from the slot's last
	// sample, as real audio would give; the rest are full-range values and extremes.
	// With hold set, the receiver holds off for a long stretch early in the phase.
	task automatic run_random(int count, idle_mode_t mode, bit hold);
		logic [15:0] value;
		case (mode)
			IDLE_NONE:     begin send_pct = 0;  stall_pct <= 0;  end
			IDLE_SENDER:   begin send_pct = 54; stall_pct <= 0;  end
			IDLE_RECEIVER: begin send_pct = 0;  stall_pct <= 54; end
			default:       begin send_pct = 28; stall_pct <= 28; end
		endcase
		for (int i = 0; i < count; i++) begin
			hold_go <= (hold && i == 4);
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 3))
						0:       value = 16'h8000;
						1:       value = 16'h7FFF;
						2:       value = 16'h0000;
						default: value = 16'hFFFF;
					endcase
				end
				1, 2, 3: value = 16'($urandom);
				default: value = last_tx[tx_slot] + 16'($urandom_range(0, 256)) - 16'd128;
			endcase
			send_sample(value);
		end
		sample_valid <= 1'b0;
		hold_go      <= 1'b0;
		settle();
		send_pct = 0;
		stall_pct <= 0;
	endtask

	initial begin
		for (int k = 0; k < tsae_pkg::SLOTS; k++) last_tx[k] = '0;

		// Hold reset, then release it once and never again.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of all registers.
		apb_read(tsae_pkg::REG_FPS);
		apb_read(tsae_pkg::REG_SPW);
		apb_read(tsae_pkg::REG_SHIFT);
		apb_read(tsae_pkg::REG_THR);

		// Directed: a window of two frames and one segment, no shift, and a
		// threshold just below the largest step so the active flag splits the slots.
		configure(2, 1, 0, 32767);
		for (int i = 0; i < 32; i++) send_sample(directed_sample(i));
		sample_valid <= 1'b0;
		settle();

		// Two-frame window again with a threshold that some steps pass.
		configure(2, 1, 0, 500);
		run_random(64, IDLE_SENDER, 1'b0);

		// Short segment and zero window: every frame stands alone, sums stay zero,
		// the widest shift, and a zero threshold marks every slot active.
		configure(0, 0, 31, 0);
		run_random(32, IDLE_RECEIVER, 1'b0);

		// Longest segment and window; only a part of a segment is sent.
		configure(4096, 16, 7, 2000);
		run_random(40, IDLE_BOTH, 1'b0);

		// Lower the limits in mid-segment: the frame counter already stands at the new
		// limit, so the next frame boundary closes the window. The receiver holds off
		// early on while samples keep coming, so the block fills and stalls its input.
		configure(2, 1, 5, 300);
		run_random(72, IDLE_NONE, 1'b1);

		// All ones into every register: values are cut to width, the segment and
		// window lengths clamp to their maximum, and the threshold is at its top.
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(20, IDLE_SENDER, 1'b0);

		// Back to short limits from inside a long segment, near the reset settings.
		configure(3, 2, 9, 10);
		run_random(80, IDLE_BOTH, 1'b0);

		configure(2, 2, 1, 4000);
		run_random(64, IDLE_RECEIVER, 1'b0);

		$display("Run covered %0d samples under %0d register settings, %0d slot reports checked",
			samples_sent, settings_used, reports_checked);
		$display("(wrapped differences, clamped and lowered limits, long receiver hold-off)");
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
